// File: hw/rtl/waveform_min_max_envelope_assert.svh
// Assertion macros for the waveform envelope block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WAVEFORM_MIN_MAX_ENVELOPE_ASSERT_SVH
`define WAVEFORM_MIN_MAX_ENVELOPE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge once reset is released.
`define WVENV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same check, but also active while reset is held.
`define WVENV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WVENV_ASSERT(lbl, clk, rst_n, prop, msg)
`define WVENV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/wvenv_pkg.sv
// Shared types and constants of the waveform envelope block.
// No dependencies; imported by every module of the block.
`default_nettype none
package wvenv_pkg;

    // Configuration register indexes
    localparam logic CFG_SAMPLES_PER_COLUMN = 1'b0;
    localparam logic CFG_DISPLAY_ENABLED    = 1'b1;

    // Division by 300 as (x * RECIP) >> RECIP_SHIFT, exact for x <= 32768
    localparam logic [15:0] RECIP       = 16'd55925;
    localparam int          RECIP_SHIFT = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [15:0] samples_per_column;
        logic        display_enabled;
    } cfg_t;

    // One closed column, handed from the front to the back
    typedef struct packed {
        logic [9:0]  column;
        logic [14:0] max_mag;   // column maximum floored at zero
        logic [15:0] min_mag;   // magnitude of column minimum capped at zero
        logic        last;
    } col_entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/wvenv_front.sv
// Front end: accepts samples, folds them into running extremes, closes columns.
// Depends on wvenv_pkg and the assertion macro header.
`default_nettype none
`include "waveform_min_max_envelope_assert.svh"
module wvenv_front
    import wvenv_pkg::*;
#(
    parameter int COLUMNS = 600
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              accept,
    input  wire logic signed [15:0] sample,
    input  wire logic              new_frame,
    output logic                   push,
    output col_entry_t             entry
);

    localparam logic [9:0] LAST_COL = 10'(COLUMNS - 1);

    logic [9:0]         col_reg, col_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic signed [15:0] max_reg, max_next;
    logic signed [15:0] min_reg, min_next;
    logic               done_reg, done_next;

    logic [9:0]         base_col;
    logic [15:0]        base_cnt, cnt_inc, need;
    logic signed [15:0] base_max, base_min, fold_max, fold_min;
    logic               base_done, close, is_last;

    always_comb begin
        base_col  = new_frame ? 10'd0 : col_reg;
        base_cnt  = new_frame ? 16'd0 : cnt_reg;
        base_max  = new_frame ? 16'sd0 : max_reg;
        base_min  = new_frame ? 16'sd0 : min_reg;
        base_done = new_frame ? 1'b0 : done_reg;

        fold_max = (sample > base_max) ? sample : base_max;
        fold_min = (sample < base_min) ? sample : base_min;
        cnt_inc  = base_cnt + 16'd1;
        need     = (cfg.samples_per_column == 16'd0) ? 16'd1 : cfg.samples_per_column;
        close    = (cnt_inc >= need);
        is_last  = (base_col >= LAST_COL);

        col_next  = base_col;
        cnt_next  = base_cnt;
        max_next  = base_max;
        min_next  = base_min;
        done_next = base_done;
        if (!base_done) begin
            if (close) begin
                cnt_next  = 16'd0;
                max_next  = 16'sd0;
                min_next  = 16'sd0;
                col_next  = is_last ? 10'd0 : base_col + 10'd1;
                done_next = is_last;
            end else begin
                cnt_next = cnt_inc;
                max_next = fold_max;
                min_next = fold_min;
            end
        end

        push          = accept && !base_done && close;
        entry.column  = base_col;
        entry.last    = is_last;
        entry.max_mag = cfg.display_enabled ? fold_max[14:0] : 15'd0;
        entry.min_mag = cfg.display_enabled ? 16'd0 - $unsigned(fold_min) : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= 10'd0;
            cnt_reg  <= 16'd0;
            max_reg  <= 16'sd0;
            min_reg  <= 16'sd0;
            done_reg <= 1'b0;
        end else if (accept) begin
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            max_reg  <= max_next;
            min_reg  <= min_next;
            done_reg <= done_next;
        end
    end

    `WVENV_ASSERT(a_done_clears, aclk, aresetn, done_reg |-> (col_reg == 10'd0 && cnt_reg == 16'd0), "finished frame left counters set")
    `WVENV_ASSERT(a_col_range, aclk, aresetn, col_reg <= LAST_COL, "column counter past last column")
    `WVENV_ASSERT(a_extremes_sign, aclk, aresetn, (max_reg >= 16'sd0) && (min_reg <= 16'sd0), "running extremes crossed zero")

endmodule
`default_nettype wire

// File: hw/rtl/wvenv_queue.sv
// Short FIFO of closed columns between the front and the back.
// Depends on wvenv_pkg and the assertion macro header.
`default_nettype none
`include "waveform_min_max_envelope_assert.svh"
module wvenv_queue
    import wvenv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire col_entry_t push_data,
    input  wire logic       pop,
    output logic            full,
    output logic            not_empty,
    output col_entry_t      head
);

    col_entry_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    `WVENV_ASSERT(a_no_overflow, aclk, aresetn, push |-> !full, "push into full queue")
    `WVENV_ASSERT(a_no_underflow, aclk, aresetn, pop |-> not_empty, "pop from empty queue")
    `WVENV_ASSERT(a_count_range, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule
`default_nettype wire

// File: hw/rtl/wvenv_back.sv
// Back end: scales a closed column by 1/300 and holds it in the output register.
// Depends on wvenv_pkg and the assertion macro header.
`default_nettype none
`include "waveform_min_max_envelope_assert.svh"
module wvenv_back
    import wvenv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_not_empty,
    input  wire col_entry_t q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [9:0]      column_index,
    output logic [6:0]      upper_value,
    output logic [7:0]      lower_value,
    output logic            last_column
);

    logic        valid_reg;
    logic [9:0]  col_reg;
    logic [6:0]  up_reg;
    logic [7:0]  lo_reg;
    logic        last_reg;

    logic [31:0] up_prod, lo_prod;
    logic [6:0]  up_q, lo_q;

    always_comb begin
        up_prod = 32'({1'b0, q_head.max_mag}) * 32'(RECIP);
        lo_prod = 32'(q_head.min_mag) * 32'(RECIP);
        up_q    = up_prod[RECIP_SHIFT+6:RECIP_SHIFT];
        lo_q    = lo_prod[RECIP_SHIFT+6:RECIP_SHIFT];
        q_pop   = q_not_empty && (!valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            col_reg  <= q_head.column;
            up_reg   <= up_q;
            lo_reg   <= 8'd0 - {1'b0, lo_q};
            last_reg <= q_head.last;
        end
    end

    assign m_valid      = valid_reg;
    assign column_index = col_reg;
    assign upper_value  = up_reg;
    assign lower_value  = lo_reg;
    assign last_column  = last_reg;

    `WVENV_ASSERT(a_upper_range, aclk, aresetn, valid_reg |-> (up_reg <= 7'd109), "upper value out of range")
    `WVENV_ASSERT(a_lower_range, aclk, aresetn, valid_reg |-> ($signed(lo_reg) <= 8'sd0 && $signed(lo_reg) >= -8'sd109), "lower value out of range")
    `WVENV_ASSERT(a_pop_loads, aclk, aresetn, q_pop |=> valid_reg, "popped column not presented")

endmodule
`default_nettype wire

// File: hw/rtl/waveform_min_max_envelope.sv
// Waveform min/max envelope decimator, top level.
// Depends on wvenv_pkg, wvenv_front, wvenv_queue, wvenv_back.
//
// Usage:
//   Samples enter on the s_ stream: s_tdata carries the signed 16-bit sample,
//   s_tuser the new-frame flag, which restarts the frame at column zero before
//   the sample is folded in. Every samples_per_column samples close one column,
//   and one envelope transaction leaves on the m_ stream with column index,
//   upper and lower peak (each divided by 300, truncated toward zero); m_tlast
//   marks the final column of a frame. After that column, samples are taken
//   and dropped until a new-frame flag arrives.
//   Throughput: one sample per cycle while the queue has room. The front
//   folds a sample into its compare-and-count registers; the back issues at
//   most one column a cycle. Path: a closed column is written into the queue,
//   then scaled by the multiply into the output register that drives m_tvalid.
//   Stall: a four-deep column queue separates the two halves; s_tready drops
//   only once the queue is full while m_tready is held low.
//   Reset: aresetn low, synchronous; clears counters, extremes, queue and the
//   output valid; samples_per_column returns to 1, display_enabled to 0.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 samples per
//   column, 1 display enable) at the clock edge; write only while idle.
`default_nettype none
module waveform_min_max_envelope
    import wvenv_pkg::*;
#(
    parameter int COLUMNS = 600
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // sample stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample_value
    input  wire logic        s_tuser,   // [0] new_frame
    // envelope stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [9:0] column_index, [16:10] upper_value,
                                        // [24:17] lower_value, [31:25] zero
    output logic             m_tlast    // last_column
);

    cfg_t       cfg_reg;
    logic       accept, push, q_full, q_not_empty, q_pop;
    col_entry_t push_entry, q_head;
    logic [9:0] column_index;
    logic [6:0] upper_value;
    logic [7:0] lower_value;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.samples_per_column <= 16'd1;
            cfg_reg.display_enabled    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SAMPLES_PER_COLUMN: cfg_reg.samples_per_column <= cfg_wdata;
                CFG_DISPLAY_ENABLED:    cfg_reg.display_enabled    <= cfg_wdata[0];
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // Any accepted sample may close a column, so room in the queue gates input
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    wvenv_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .accept    (accept),
        .sample    ($signed(s_tdata)),
        .new_frame (s_tuser),
        .push      (push),
        .entry     (push_entry)
    );

    wvenv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    wvenv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .column_index (column_index),
        .upper_value  (upper_value),
        .lower_value  (lower_value),
        .last_column  (m_tlast)
    );

    assign m_tdata = {7'd0, lower_value, upper_value, column_index};

endmodule
`default_nettype wire
